### design/fsag_pkg.sv
// fsag_pkg: shared widths, register indexes, reset values and helpers
// for the flow setup admission governor. No dependencies.

package fsag_pkg;

  // table geometry
  localparam int MIN_TABLE_BYTES_DEF = 16384;
  localparam int MAX_TABLE_BYTES_DEF = 262144;
  localparam int ROW_LOG2            = 2;    // four counter bytes per memory row
  localparam int GEN_DIV_LOG2        = 2;    // generation length is size / 4 packets

  // field and state widths
  localparam int HASH_W  = 32;
  localparam int TIME_W  = 32;
  localparam int NPKT_W  = 8;
  localparam int THR_W   = 4;
  localparam int MS_W    = 16;
  localparam int SIZE_W  = 5;
  localparam int PKT_W   = 18;
  localparam int CNT_W   = 20;
  localparam int NIB_W   = 4;

  localparam logic [PKT_W-1:0] PKT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // shortcut terms
  localparam logic [CNT_W-1:0] SHORTCUT_MIN_FLOWS = CNT_W'(64);
  localparam int               SHORTCUT_SHIFT     = 4;   // flows / 16
  localparam int               SHORTCUT_HASH_W    = 6;   // low hash bits tested

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_GEN_MS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_GEN_MS     = 2'd2;

  localparam logic [THR_W-1:0] THR_RST  = 4'd5;
  localparam logic [MS_W-1:0]  FAST_RST = 16'd1000;
  localparam logic [MS_W-1:0]  SLOW_RST = 16'd5000;

  // commands
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_MAINT = 1'b1;

  function automatic int floor_log2(input int v);
    int r;
    int x;
    r = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      r = r + 1;
    end
    return r;
  endfunction

endpackage

### design/fsag_table.sv
// fsag_table: single-clock counter memory, one write port and one
// registered read port. Row width defaults from fsag_pkg.

module fsag_table #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8 << fsag_pkg::ROW_LOG2
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/flow_setup_admission_governor.sv
// flow_setup_admission_governor: admission filter over a resizable table of 4-bit counters.
// An accepted item is latched and evaluated; shortcut and maintenance items finish there, while
// table items read their row and then write back the updated counter. A generation change first
// clears 2^(size_log2-2) rows, then reads the row for items that then go to the table.
// One item at a time: the input stalls until the item's result is registered at the output.
// Reset: synchronous; afterwards the block clears MIN_TABLE_BYTES/4 rows, stalling input.
// Depends on fsag_pkg and fsag_table.

module flow_setup_admission_governor #(
  parameter int MIN_TABLE_BYTES = fsag_pkg::MIN_TABLE_BYTES_DEF,
  parameter int MAX_TABLE_BYTES = fsag_pkg::MAX_TABLE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [fsag_pkg::HASH_W-1:0]         in_flow_hash,
  input  logic [fsag_pkg::NPKT_W-1:0]         in_packet_count,
  input  logic [fsag_pkg::TIME_W-1:0]         in_now_ms,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_admit,
  output logic                                out_via_shortcut,
  output logic                                out_idle,
  output logic [fsag_pkg::SIZE_W-1:0]         out_table_bytes_log2,
  // configuration
  input  logic                                cfg_we,
  input  logic [fsag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsag_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ALLOC      = (MAX_TABLE_BYTES > MIN_TABLE_BYTES) ? MAX_TABLE_BYTES
                                                                  : MIN_TABLE_BYTES;
  localparam int BA         = $clog2(ALLOC);
  localparam int RA         = BA - fsag_pkg::ROW_LOG2;
  localparam int ROW_W      = 8 << fsag_pkg::ROW_LOG2;
  localparam int LANE_W     = fsag_pkg::ROW_LOG2;
  localparam int SIZE_W     = fsag_pkg::SIZE_W;
  localparam int PKT_W      = fsag_pkg::PKT_W;
  localparam int CNT_W      = fsag_pkg::CNT_W;
  localparam int NIB_W      = fsag_pkg::NIB_W;
  localparam int NPKT_W     = fsag_pkg::NPKT_W;
  localparam int TIME_W     = fsag_pkg::TIME_W;
  localparam int SUM_W      = NPKT_W + 1;

  localparam logic [SIZE_W-1:0] MIN_LOG2 = SIZE_W'(fsag_pkg::floor_log2(MIN_TABLE_BYTES));
  localparam logic [SIZE_W-1:0] MAX_LOG2 = SIZE_W'(fsag_pkg::floor_log2(MAX_TABLE_BYTES));
  localparam logic [SIZE_W-1:0] ROW_SH   = SIZE_W'(fsag_pkg::ROW_LOG2);
  localparam logic [SIZE_W-1:0] GEN_SH   = SIZE_W'(fsag_pkg::GEN_DIV_LOG2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  // control state
  logic [2:0]                      state_r, state_nxt;
  logic [RA-1:0]                   clr_addr_r, clr_addr_nxt;
  logic                            item_pend_r, item_pend_nxt;
  logic [SIZE_W-1:0]               size_r, size_nxt;
  logic [TIME_W-1:0]               start_r, start_nxt;
  logic [PKT_W-1:0]                pkt_r, pkt_nxt;
  logic [CNT_W-1:0]                flows_r, flows_nxt;
  logic [CNT_W-1:0]                setups_r, setups_nxt;
  logic [fsag_pkg::THR_W-1:0]      thr_r, thr_nxt;
  logic [fsag_pkg::MS_W-1:0]       fast_r, fast_nxt;
  logic [fsag_pkg::MS_W-1:0]       slow_r, slow_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // item and result payload
  logic                            cmd_r, cmd_nxt;
  logic [fsag_pkg::HASH_W-1:0]     hash_r, hash_nxt;
  logic [NPKT_W-1:0]               n_r, n_nxt;
  logic [TIME_W-1:0]               now_r, now_nxt;
  logic                            need_read_r, need_read_nxt;
  logic                            res_inst_r, res_inst_nxt;
  logic                            res_sc_r, res_sc_nxt;
  logic                            out_inst_r, out_inst_nxt;
  logic                            out_sc_r, out_sc_nxt;
  logic                            out_idle_r, out_idle_nxt;
  logic [SIZE_W-1:0]               out_size_r, out_size_nxt;

  // table port
  logic                            tbl_we;
  logic [RA-1:0]                   tbl_wa;
  logic [ROW_W-1:0]                tbl_wd;
  logic                            tbl_re;
  logic [ROW_W-1:0]                tbl_rd;

  // generation and shortcut decision
  logic                            is_maint;
  logic [TIME_W-1:0]               elapsed;
  logic [PKT_W:0]                  pkt_sum;
  logic [PKT_W:0]                  gen_len;
  logic                            gen_end;
  logic                            can_grow;
  logic                            can_shrink;
  logic                            maint_go;
  logic                            new_gen;
  logic [SIZE_W-1:0]               size_new;
  logic [PKT_W-1:0]                pkt_new;
  logic [CNT_W-1:0]                flows_h;
  logic [CNT_W-1:0]                setups_h;
  logic                            shortcut;

  // addressing and counter update
  logic [SIZE_W-1:0]               size_sel;
  logic [BA-1:0]                   byte_mask;
  logic [BA-1:0]                   byte_idx;
  logic [RA-1:0]                   row_addr;
  logic [LANE_W-1:0]               lane;
  logic [RA-1:0]                   clr_last;
  logic [7:0]                      old_byte;
  logic [NIB_W-1:0]                old_cnt;
  logic [SUM_W-1:0]                new_cnt;
  logic                            inst_mod;
  logic [NIB_W-1:0]                new_nib;
  logic [7:0]                      new_byte;
  logic [ROW_W-1:0]                new_row;

  logic                            fin;
  logic                            fin_inst;
  logic                            fin_sc;
  logic                            out_free;

  fsag_table #(
    .ADDR_W (RA),
    .DATA_W (ROW_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_wa),
    .wdata (tbl_wd),
    .re    (tbl_re),
    .raddr (row_addr),
    .rdata (tbl_rd)
  );

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_admit            = out_inst_r;
  assign out_via_shortcut     = out_sc_r;
  assign out_idle             = out_idle_r;
  assign out_table_bytes_log2 = out_size_r;
  assign out_free             = !out_valid_r || !out_stall;

  // generation bookkeeping, evaluated on the latched item
  always_comb begin
    is_maint   = (cmd_r == fsag_pkg::CMD_MAINT);
    elapsed    = now_r - start_r;
    pkt_sum    = {1'b0, pkt_r} + (PKT_W+1)'(n_r);
    gen_len    = (PKT_W+1)'(1) << (size_r - GEN_SH);
    gen_end    = !is_maint && (pkt_sum >= gen_len);
    can_grow   = (elapsed < TIME_W'(fast_r)) && (size_r < MAX_LOG2);
    can_shrink = (elapsed > TIME_W'(slow_r)) && (size_r > MIN_LOG2);
    maint_go   = is_maint && can_shrink;
    new_gen    = gen_end || maint_go;

    size_new = size_r;
    if (maint_go) begin
      size_new = size_r - SIZE_W'(1);
    end else if (gen_end) begin
      if (can_grow) begin
        size_new = size_r + SIZE_W'(1);
      end else if (can_shrink) begin
        size_new = size_r - SIZE_W'(1);
      end
    end

    if (new_gen) begin
      pkt_new = '0;
    end else if (is_maint) begin
      pkt_new = pkt_r;
    end else if (pkt_sum > (PKT_W+1)'(fsag_pkg::PKT_MAX)) begin
      pkt_new = fsag_pkg::PKT_MAX;
    end else begin
      pkt_new = pkt_sum[PKT_W-1:0];
    end

    flows_h  = new_gen ? (flows_r >> 1) : flows_r;
    setups_h = new_gen ? (setups_r >> 1) : setups_r;
    shortcut = !is_maint
               && (setups_h >= flows_h - (flows_h >> fsag_pkg::SHORTCUT_SHIFT))
               && (flows_h >= fsag_pkg::SHORTCUT_MIN_FLOWS)
               && (hash_r[fsag_pkg::SHORTCUT_HASH_W-1:0] != '0);
  end

  // table addressing and nibble update
  always_comb begin
    size_sel  = (state_r == S_EVAL) ? size_new : size_r;
    byte_mask = BA'(((BA+1)'(1) << size_sel) - (BA+1)'(1));
    byte_idx  = hash_r[BA:1] & byte_mask;
    row_addr  = byte_idx[BA-1:LANE_W];
    lane      = byte_idx[LANE_W-1:0];
    clr_last  = RA'(((RA+1)'(1) << (size_r - ROW_SH)) - (RA+1)'(1));

    old_byte = tbl_rd[8*lane +: 8];
    old_cnt  = hash_r[0] ? old_byte[7:4] : old_byte[3:0];
    new_cnt  = SUM_W'(n_r) + SUM_W'(old_cnt);
    inst_mod = (new_cnt >= SUM_W'(thr_r));
    new_nib  = inst_mod ? '0 : new_cnt[NIB_W-1:0];
    new_byte = hash_r[0] ? {new_nib, old_byte[3:0]} : {old_byte[7:4], new_nib};
    new_row  = tbl_rd;
    new_row[8*lane +: 8] = new_byte;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    item_pend_nxt = item_pend_r;
    size_nxt      = size_r;
    start_nxt     = start_r;
    pkt_nxt       = pkt_r;
    flows_nxt     = flows_r;
    setups_nxt    = setups_r;
    thr_nxt       = thr_r;
    fast_nxt      = fast_r;
    slow_nxt      = slow_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    hash_nxt      = hash_r;
    n_nxt         = n_r;
    now_nxt       = now_r;
    need_read_nxt = need_read_r;
    res_inst_nxt  = res_inst_r;
    res_sc_nxt    = res_sc_r;
    out_inst_nxt  = out_inst_r;
    out_sc_nxt    = out_sc_r;
    out_idle_nxt  = out_idle_r;
    out_size_nxt  = out_size_r;
    tbl_we        = 1'b0;
    tbl_wa        = clr_addr_r;
    tbl_wd        = '0;
    tbl_re        = 1'b0;
    fin           = 1'b0;
    fin_inst      = 1'b0;
    fin_sc        = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        fsag_pkg::CFG_SETUP_THRESHOLD: thr_nxt  = cfg_wdata[fsag_pkg::THR_W-1:0];
        fsag_pkg::CFG_FAST_GEN_MS:     fast_nxt = cfg_wdata[fsag_pkg::MS_W-1:0];
        fsag_pkg::CFG_SLOW_GEN_MS:     slow_nxt = cfg_wdata[fsag_pkg::MS_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          hash_nxt  = in_flow_hash;
          n_nxt     = in_packet_count;
          now_nxt   = in_now_ms;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        size_nxt      = size_new;
        start_nxt     = new_gen ? now_r : start_r;
        pkt_nxt       = pkt_new;
        flows_nxt     = flows_h;
        setups_nxt    = setups_h;
        res_inst_nxt  = shortcut;
        res_sc_nxt    = shortcut;
        need_read_nxt = !is_maint && !shortcut;
        if (new_gen) begin
          clr_addr_nxt  = '0;
          item_pend_nxt = 1'b1;
          state_nxt     = S_CLEAR;
        end else if (!is_maint && !shortcut) begin
          tbl_re    = 1'b1;
          state_nxt = S_MOD;
        end else begin
          fin      = 1'b1;
          fin_inst = shortcut;
          fin_sc   = shortcut;
        end
      end
      S_CLEAR: begin
        tbl_we       = 1'b1;
        tbl_wa       = clr_addr_r;
        clr_addr_nxt = clr_addr_r + RA'(1);
        if (clr_addr_r == clr_last) begin
          // the clear after reset has no item behind it
          if (!item_pend_r) begin
            state_nxt = S_IDLE;
          end else if (need_read_r) begin
            state_nxt = S_READ;
          end else begin
            fin      = 1'b1;
            fin_inst = res_inst_r;
            fin_sc   = res_sc_r;
          end
        end
      end
      S_READ: begin
        tbl_re    = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        tbl_we = 1'b1;
        tbl_wa = row_addr;
        tbl_wd = new_row;
        if (old_cnt == '0 && flows_r != fsag_pkg::CNT_MAX) begin
          flows_nxt = flows_r + CNT_W'(1);
        end
        if (inst_mod && setups_r != fsag_pkg::CNT_MAX) begin
          setups_nxt = setups_r + CNT_W'(1);
        end
        fin      = 1'b1;
        fin_inst = inst_mod;
        fin_sc   = 1'b0;
      end
      S_HOLD: begin
        fin      = 1'b1;
        fin_inst = res_inst_r;
        fin_sc   = res_sc_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // idle is judged on the state this item leaves behind
    out_idle_nxt = out_idle_r;
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_inst_nxt  = fin_inst;
        out_sc_nxt    = fin_sc;
        out_idle_nxt  = (size_nxt == MIN_LOG2) && ((now_r - start_nxt) > TIME_W'(slow_r));
        out_size_nxt  = size_nxt;
        state_nxt     = S_IDLE;
      end else begin
        res_inst_nxt = fin_inst;
        res_sc_nxt   = fin_sc;
        state_nxt    = S_HOLD;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      item_pend_r <= 1'b0;
      size_r      <= MIN_LOG2;
      start_r     <= '0;
      pkt_r       <= '0;
      flows_r     <= '0;
      setups_r    <= '0;
      thr_r       <= fsag_pkg::THR_RST;
      fast_r      <= fsag_pkg::FAST_RST;
      slow_r      <= fsag_pkg::SLOW_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      item_pend_r <= item_pend_nxt;
      size_r      <= size_nxt;
      start_r     <= start_nxt;
      pkt_r       <= pkt_nxt;
      flows_r     <= flows_nxt;
      setups_r    <= setups_nxt;
      thr_r       <= thr_nxt;
      fast_r      <= fast_nxt;
      slow_r      <= slow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    hash_r      <= hash_nxt;
    n_r         <= n_nxt;
    now_r       <= now_nxt;
    need_read_r <= need_read_nxt;
    res_inst_r  <= res_inst_nxt;
    res_sc_r    <= res_sc_nxt;
    out_inst_r  <= out_inst_nxt;
    out_sc_r    <= out_sc_nxt;
    out_idle_r  <= out_idle_nxt;
    out_size_r  <= out_size_nxt;
  end

`ifndef NO_ASSERTIONS
  // single-port discipline: a read never meets a write in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl_we && tbl_re))
    else $error("table read and write in the same cycle");

  // table size stays within the configured bounds
  a_size_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r >= MIN_LOG2) && ((size_r <= MAX_LOG2) || (size_r == MIN_LOG2)))
    else $error("table size out of bounds");

  // an accepted item is evaluated in the very next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EVAL))
    else $error("accepted item not evaluated");

  // a new result only appears while an item is in progress
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) != S_IDLE))
    else $error("result without an item");
`endif

endmodule
